@@ src/tksc_pkg.sv @@
// ============================================================================
// tksc_pkg: shared types and constants of the touch key seat sequencer
// Key and channel numbering, register indexes, configuration and lane
// status structs, and the level-to-command step table.
// ============================================================================
package tksc_pkg;

    localparam int NUM_KEYS  = 8;
    localparam int NUM_HOLD  = 6;   // held seat command channels (sound is not held)
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [7:0] HELD_MAX     = 8'hFF;
    localparam logic [7:0] DEBOUNCE_RST = 8'd2;
    localparam logic [7:0] LONG_RST     = 8'd20;
    localparam logic [1:0] REPEAT_RST   = 2'd3;

    // key numbers within touch_keys
    localparam int KEY_LEFT_VENT  = 0;
    localparam int KEY_LEFT_HEAT  = 1;
    localparam int KEY_RIGHT_HEAT = 2;
    localparam int KEY_RIGHT_VENT = 3;
    localparam int KEY_LEFT_FWD   = 4;
    localparam int KEY_RIGHT_BWD  = 5;
    localparam int KEY_RIGHT_FWD  = 6;
    localparam int KEY_LEFT_BWD   = 7;

    // held command channels
    localparam int CH_LEFT_HEAT  = 0;
    localparam int CH_RIGHT_HEAT = 1;
    localparam int CH_LEFT_VENT  = 2;
    localparam int CH_RIGHT_VENT = 3;
    localparam int CH_LEFT_BACK  = 4;
    localparam int CH_RIGHT_BACK = 5;

    localparam logic [2:0] BACK_FWD = 3'd1;
    localparam logic [2:0] BACK_BWD = 3'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEAT_EN    = 3'd0,
        CFG_VENT_EN    = 3'd1,
        CFG_DEBOUNCE   = 3'd2,
        CFG_LONG_PRESS = 3'd3,
        CFG_REPEAT     = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic       heat_enable;
        logic       vent_enable;
        logic [7:0] debounce_ticks;
        logic [7:0] long_press_ticks;
        logic [1:0] repeat_count;
    } tksc_cfg_t;

    typedef struct packed {
        logic trigger;    // trigger pending after this tick's qualify step
        logic new_press;  // first trigger of a press, raised this tick
    } tksc_lane_t;

    typedef struct packed {
        logic [1:0] left_vent_level;
        logic [1:0] right_vent_level;
        logic [1:0] left_heat_level;
        logic [1:0] right_heat_level;
    } tksc_levels_t;

    typedef struct packed {
        logic [2:0] left_heat_cmd;
        logic [2:0] right_heat_cmd;
        logic [2:0] left_vent_cmd;
        logic [2:0] right_vent_cmd;
        logic [1:0] left_backrest_cmd;
        logic [1:0] right_backrest_cmd;
        logic       key_sound;
    } tksc_result_t;

    // reported level 0,1,2,3 steps to command 2,3,4,1
    function automatic logic [2:0] level_to_cmd(input logic [1:0] level);
        logic [2:0] cmd;
        unique case (level)
            2'd0: cmd = 3'd2;
            2'd1: cmd = 3'd3;
            2'd2: cmd = 3'd4;
            2'd3: cmd = 3'd1;
        endcase
        return cmd;
    endfunction

endpackage

@@ src/tksc_if.sv @@
// ============================================================================
// tksc_in_if / tksc_out_if: valid/ready channels of the seat sequencer
// Scan tick requests in, seat command requests out.
// ============================================================================
interface tksc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] touch_keys;
    logic [1:0] left_vent_level;
    logic [1:0] right_vent_level;
    logic [1:0] left_heat_level;
    logic [1:0] right_heat_level;

    modport source (output valid, touch_keys, left_vent_level, right_vent_level,
                    left_heat_level, right_heat_level, input ready);
    modport sink (input valid, touch_keys, left_vent_level, right_vent_level,
                  left_heat_level, right_heat_level, output ready);
endinterface

interface tksc_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] left_heat_cmd;
    logic [2:0] right_heat_cmd;
    logic [2:0] left_vent_cmd;
    logic [2:0] right_vent_cmd;
    logic [1:0] left_backrest_cmd;
    logic [1:0] right_backrest_cmd;
    logic       key_sound;

    modport source (output valid, left_heat_cmd, right_heat_cmd, left_vent_cmd,
                    right_vent_cmd, left_backrest_cmd, right_backrest_cmd,
                    key_sound, input ready);
    modport sink (input valid, left_heat_cmd, right_heat_cmd, left_vent_cmd,
                  right_vent_cmd, left_backrest_cmd, right_backrest_cmd,
                  key_sound, output ready);
endinterface

@@ src/tksc_key_lane.sv @@
// ============================================================================
// tksc_key_lane: debounce and long-press qualifier for one touch key
// Counts held ticks, latches the first trigger of a press and keeps a
// trigger pending until the merge stage takes it.
// ============================================================================
module tksc_key_lane
    import tksc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic       touched,
    input  tksc_cfg_t  cfg,
    input  logic       take,
    output tksc_lane_t status
);

    logic [7:0] held_reg, held_next;
    logic       latched_reg, latched_next;
    logic       pending_reg, pending_next;
    logic       ge_debounce;
    logic       ge_long;

    // qualify against the count held before this tick
    assign ge_debounce = (held_reg >= cfg.debounce_ticks);
    assign ge_long     = (held_reg >= cfg.long_press_ticks);

    assign status.new_press = touched & ge_debounce & ~latched_reg;
    assign status.trigger   = pending_reg | status.new_press | (touched & ge_long);

    // advance the held count, saturating; drop it on release
    always_comb
    begin
        if (touched)
        begin
            held_next    = (held_reg == HELD_MAX) ? held_reg : held_reg + 8'd1;
            latched_next = latched_reg | ge_debounce;
        end
        else
        begin
            held_next    = '0;
            latched_next = 1'b0;
        end
        pending_next = status.trigger & ~take;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg    <= '0;
            latched_reg <= 1'b0;
            pending_reg <= 1'b0;
        end
        else if (accept)
        begin
            held_reg    <= held_next;
            latched_reg <= latched_next;
            pending_reg <= pending_next;
        end
    end

endmodule

@@ src/tksc_merge.sv @@
// ============================================================================
// tksc_merge: map lane triggers to seat commands and hold them
// Gates heat and vent by their enables, resolves backrest direction and
// holds each command for repeat_count ticks.
// ============================================================================
module tksc_merge
    import tksc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  tksc_cfg_t                  cfg,
    input  tksc_levels_t               levels,
    input  tksc_lane_t [NUM_KEYS-1:0]  lanes,
    output logic [NUM_KEYS-1:0]        take,
    output tksc_result_t               result
);

    logic [1:0] rem_reg [NUM_HOLD];
    logic [1:0] rem_next [NUM_HOLD];
    logic [2:0] val_reg [NUM_HOLD];
    logic [2:0] val_next [NUM_HOLD];
    logic [2:0] shown [NUM_HOLD];
    logic [NUM_HOLD-1:0] load;
    logic [2:0] load_val [NUM_HOLD];
    logic [NUM_KEYS-1:0] trig;
    logic [NUM_KEYS-1:0] press;

    always_comb
    begin
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            trig[k]  = lanes[k].trigger;
            press[k] = lanes[k].new_press;
        end
    end

    // take a key's trigger only where its function is enabled
    always_comb
    begin
        take                 = '1;
        take[KEY_LEFT_VENT]  = cfg.vent_enable;
        take[KEY_RIGHT_VENT] = cfg.vent_enable;
        take[KEY_LEFT_HEAT]  = cfg.heat_enable;
        take[KEY_RIGHT_HEAT] = cfg.heat_enable;
    end

    // map triggers to channel loads; backward wins over forward
    always_comb
    begin
        load[CH_LEFT_HEAT]      = cfg.heat_enable & trig[KEY_LEFT_HEAT];
        load_val[CH_LEFT_HEAT]  = level_to_cmd(levels.left_heat_level);
        load[CH_RIGHT_HEAT]     = cfg.heat_enable & trig[KEY_RIGHT_HEAT];
        load_val[CH_RIGHT_HEAT] = level_to_cmd(levels.right_heat_level);
        load[CH_LEFT_VENT]      = cfg.vent_enable & trig[KEY_LEFT_VENT];
        load_val[CH_LEFT_VENT]  = level_to_cmd(levels.left_vent_level);
        load[CH_RIGHT_VENT]     = cfg.vent_enable & trig[KEY_RIGHT_VENT];
        load_val[CH_RIGHT_VENT] = level_to_cmd(levels.right_vent_level);
        load[CH_LEFT_BACK]      = trig[KEY_LEFT_FWD] | trig[KEY_LEFT_BWD];
        load_val[CH_LEFT_BACK]  = trig[KEY_LEFT_BWD] ? BACK_BWD : BACK_FWD;
        load[CH_RIGHT_BACK]     = trig[KEY_RIGHT_FWD] | trig[KEY_RIGHT_BWD];
        load_val[CH_RIGHT_BACK] = trig[KEY_RIGHT_BWD] ? BACK_BWD : BACK_FWD;
    end

    // load or keep each channel, then show and count down
    always_comb
    begin
        for (int c = 0; c < NUM_HOLD; c++)
        begin
            logic [1:0] rem_eff;
            rem_eff     = load[c] ? cfg.repeat_count : rem_reg[c];
            val_next[c] = load[c] ? load_val[c] : val_reg[c];
            if (rem_eff != 2'd0)
            begin
                shown[c]    = val_next[c];
                rem_next[c] = rem_eff - 2'd1;
            end
            else
            begin
                shown[c]    = '0;
                rem_next[c] = rem_eff;
            end
        end
    end

    assign result.left_heat_cmd      = shown[CH_LEFT_HEAT];
    assign result.right_heat_cmd     = shown[CH_RIGHT_HEAT];
    assign result.left_vent_cmd      = shown[CH_LEFT_VENT];
    assign result.right_vent_cmd     = shown[CH_RIGHT_VENT];
    assign result.left_backrest_cmd  = shown[CH_LEFT_BACK][1:0];
    assign result.right_backrest_cmd = shown[CH_RIGHT_BACK][1:0];
    // a new press beeps for exactly the tick it is qualified
    assign result.key_sound          = |press;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_HOLD; c++)
            begin
                rem_reg[c] <= '0;
                val_reg[c] <= '0;
            end
        end
        else if (accept)
        begin
            for (int c = 0; c < NUM_HOLD; c++)
            begin
                rem_reg[c] <= rem_next[c];
                val_reg[c] <= val_next[c];
            end
        end
    end

endmodule

@@ src/touch_key_seat_command_sequencer_top.sv @@
// ============================================================================
// touch_key_seat_command_sequencer_top: touch key to seat command sequencer
// Eight key lanes qualify presses in parallel; a merge stage maps triggers
// to heat, vent and backrest commands and holds them for repeat_count ticks.
// ============================================================================
//  channel   | dir | handshake        | content
//  ----------+-----+------------------+------------------------------------
//  key_in    | in  | valid / ready    | touch_keys, four seat level reports
//  cmd_out   | out | valid / ready    | six seat commands, key_sound
//  cfg       | in  | cfg_we           | cfg_index, cfg_data (write only)
//
//  One scan tick request is taken per clock; its result sits in the output
//  register from the cycle after acceptance. The output register decouples the
//  sides: a new tick is taken while the result is taken in the same cycle.
//  A stalled cmd_out holds the result and blocks key_in until it is taken.
//  rst_n clears all lane and channel state and loads the register defaults.
// ============================================================================
module touch_key_seat_command_sequencer_top
    import tksc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    tksc_in_if.sink               key_in,
    tksc_out_if.source            cmd_out,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    tksc_cfg_t                 cfg_reg;
    tksc_lane_t [NUM_KEYS-1:0] lanes;
    logic [NUM_KEYS-1:0]       take;
    tksc_levels_t              levels;
    tksc_result_t              result;
    tksc_result_t              out_reg;
    logic                      out_valid_reg, out_valid_next;
    logic                      accept;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.heat_enable      <= 1'b0;
            cfg_reg.vent_enable      <= 1'b0;
            cfg_reg.debounce_ticks   <= DEBOUNCE_RST;
            cfg_reg.long_press_ticks <= LONG_RST;
            cfg_reg.repeat_count     <= REPEAT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HEAT_EN:    cfg_reg.heat_enable      <= cfg_data[0];
                CFG_VENT_EN:    cfg_reg.vent_enable      <= cfg_data[0];
                CFG_DEBOUNCE:   cfg_reg.debounce_ticks   <= cfg_data;
                CFG_LONG_PRESS: cfg_reg.long_press_ticks <= cfg_data;
                CFG_REPEAT:     cfg_reg.repeat_count     <= cfg_data[1:0];
                default:        ;
            endcase
        end
    end

    // take a request whenever the output register is free or being emptied
    assign key_in.ready = ~out_valid_reg | cmd_out.ready;
    assign accept       = key_in.valid & key_in.ready;

    assign levels.left_vent_level  = key_in.left_vent_level;
    assign levels.right_vent_level = key_in.right_vent_level;
    assign levels.left_heat_level  = key_in.left_heat_level;
    assign levels.right_heat_level = key_in.right_heat_level;

    // one qualifier lane per key
    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_lane
        tksc_key_lane u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .accept  (accept),
            .touched (key_in.touch_keys[k]),
            .cfg     (cfg_reg),
            .take    (take[k]),
            .status  (lanes[k])
        );
    end

    tksc_merge u_merge (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .cfg    (cfg_reg),
        .levels (levels),
        .lanes  (lanes),
        .take   (take),
        .result (result)
    );

    // output register: hold until taken
    assign out_valid_next = accept | (out_valid_reg & ~cmd_out.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_reg <= result;
        end
    end

    assign cmd_out.valid              = out_valid_reg;
    assign cmd_out.left_heat_cmd      = out_reg.left_heat_cmd;
    assign cmd_out.right_heat_cmd     = out_reg.right_heat_cmd;
    assign cmd_out.left_vent_cmd      = out_reg.left_vent_cmd;
    assign cmd_out.right_vent_cmd     = out_reg.right_vent_cmd;
    assign cmd_out.left_backrest_cmd  = out_reg.left_backrest_cmd;
    assign cmd_out.right_backrest_cmd = out_reg.right_backrest_cmd;
    assign cmd_out.key_sound          = out_reg.key_sound;

endmodule

@@ tb/sv/touch_key_seat_command_sequencer_top_tb.sv @@
// ============================================================================
// touch_key_seat_command_sequencer_top_tb: self-checking bench of the sequencer
// Drives scan tick requests through random stalls on both channels, predicts
// every seat command request with a cycle-free model of the key lanes and
// the held command channels, and compares each taken result in order.
// ============================================================================
import tksc_pkg::*;

localparam int         NUM_CHANS   = NUM_HOLD + 1;
localparam int         CH_SOUND    = NUM_HOLD;
localparam logic [2:0] SOUND_ON    = 3'd1;
localparam int         SHOW_LIMIT  = 10;
localparam int         STALL_LIMIT = 2000;

class seat_cmd_scoreboard;
    bit           heat_en;
    bit           vent_en;
    logic [7:0]   debounce;
    logic [7:0]   long_press;
    logic [1:0]   repeat_n;
    logic [7:0]   held [NUM_KEYS];
    bit           latched [NUM_KEYS];
    bit           armed [NUM_KEYS];
    logic [1:0]   ticks_left [NUM_CHANS];
    logic [2:0]   chan_value [NUM_CHANS];
    logic [2:0]   level_step [4];
    tksc_result_t expected_cmds [$];
    int           mismatches;

    function new();
        heat_en    = 1'b0;
        vent_en    = 1'b0;
        debounce   = DEBOUNCE_RST;
        long_press = LONG_RST;
        repeat_n   = REPEAT_RST;
        level_step = '{3'd2, 3'd3, 3'd4, 3'd1};
        mismatches = 0;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            held[k]    = '0;
            latched[k] = 1'b0;
            armed[k]   = 1'b0;
        end
        for (int c = 0; c < NUM_CHANS; c++)
        begin
            ticks_left[c] = '0;
            chan_value[c] = '0;
        end
    endfunction

    // apply a register write; unknown indexes leave the settings alone
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_HEAT_EN:    heat_en    = data[0];
            CFG_VENT_EN:    vent_en    = data[0];
            CFG_DEBOUNCE:   debounce   = data;
            CFG_LONG_PRESS: long_press = data;
            CFG_REPEAT:     repeat_n   = data[1:0];
            default:        ;
        endcase
    endfunction

    function void load_chan(int ch, logic [1:0] ticks, logic [2:0] value);
        ticks_left[ch] = ticks;
        chan_value[ch] = value;
    endfunction

    // consume a waiting trigger of one key into its command channel
    function void fire_key(int key, int ch, logic [2:0] value);
        if (armed[key])
        begin
            load_chan(ch, repeat_n, value);
            armed[key] = 1'b0;
        end
    endfunction

    // advance one scan tick and queue the command request it produces
    function void take_scan_tick(logic [7:0] keys, tksc_levels_t lv);
        tksc_result_t r;
        logic [2:0]   shown [NUM_CHANS];
        // qualify each key lane
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            if (keys[k])
            begin
                if (held[k] >= debounce)
                begin
                    if (!latched[k])
                    begin
                        armed[k] = 1'b1;
                        load_chan(CH_SOUND, 2'd1, SOUND_ON);
                    end
                    latched[k] = 1'b1;
                end
                if (held[k] >= long_press)
                    armed[k] = 1'b1;
                if (held[k] != HELD_MAX)
                    held[k] = held[k] + 8'd1;
            end
            else
            begin
                held[k]    = '0;
                latched[k] = 1'b0;
            end
        end
        // map triggers; later backrest keys override earlier ones
        if (vent_en)
        begin
            fire_key(KEY_LEFT_VENT, CH_LEFT_VENT, level_step[lv.left_vent_level]);
            fire_key(KEY_RIGHT_VENT, CH_RIGHT_VENT, level_step[lv.right_vent_level]);
        end
        if (heat_en)
        begin
            fire_key(KEY_LEFT_HEAT, CH_LEFT_HEAT, level_step[lv.left_heat_level]);
            fire_key(KEY_RIGHT_HEAT, CH_RIGHT_HEAT, level_step[lv.right_heat_level]);
        end
        fire_key(KEY_LEFT_FWD, CH_LEFT_BACK, BACK_FWD);
        fire_key(KEY_LEFT_BWD, CH_LEFT_BACK, BACK_BWD);
        fire_key(KEY_RIGHT_FWD, CH_RIGHT_BACK, BACK_FWD);
        fire_key(KEY_RIGHT_BWD, CH_RIGHT_BACK, BACK_BWD);
        // emit held values and count them down
        for (int c = 0; c < NUM_CHANS; c++)
        begin
            if (ticks_left[c] != 2'd0)
            begin
                ticks_left[c] = ticks_left[c] - 2'd1;
                shown[c] = chan_value[c];
            end
            else
                shown[c] = 3'd0;
        end
        r.left_heat_cmd      = shown[CH_LEFT_HEAT];
        r.right_heat_cmd     = shown[CH_RIGHT_HEAT];
        r.left_vent_cmd      = shown[CH_LEFT_VENT];
        r.right_vent_cmd     = shown[CH_RIGHT_VENT];
        r.left_backrest_cmd  = shown[CH_LEFT_BACK][1:0];
        r.right_backrest_cmd = shown[CH_RIGHT_BACK][1:0];
        r.key_sound          = shown[CH_SOUND][0];
        expected_cmds.push_back(r);
    endfunction

    function string show(tksc_result_t r);
        return $sformatf("lh=%0d rh=%0d lv=%0d rv=%0d lb=%0d rb=%0d snd=%0d",
                         r.left_heat_cmd, r.right_heat_cmd, r.left_vent_cmd,
                         r.right_vent_cmd, r.left_backrest_cmd,
                         r.right_backrest_cmd, r.key_sound);
    endfunction

    // compare a taken command request against the oldest prediction
    function void check_cmds(tksc_result_t got);
        tksc_result_t want;
        if (expected_cmds.size() == 0)
        begin
            mismatches++;
            if (mismatches <= SHOW_LIMIT)
                $display("unexpected command request: %s", show(got));
            return;
        end
        want = expected_cmds.pop_front();
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= SHOW_LIMIT)
                $display("command mismatch: expected %s actual %s", show(want), show(got));
        end
    endfunction
endclass

module touch_key_seat_command_sequencer_top_tb;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tksc_in_if  key_in_bus();
    tksc_out_if cmd_out_bus();

    seat_cmd_scoreboard sb;
    bit quiet_run;
    int in_calm;
    int out_calm;
    int idle_cycles;

    touch_key_seat_command_sequencer_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_in    (key_in_bus),
        .cmd_out   (cmd_out_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // track accepted requests on both channels and watch for a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (key_in_bus.valid && key_in_bus.ready)
                sb.take_scan_tick(key_in_bus.touch_keys,
                                  {key_in_bus.left_vent_level, key_in_bus.right_vent_level,
                                   key_in_bus.left_heat_level, key_in_bus.right_heat_level});
            if (cmd_out_bus.valid && cmd_out_bus.ready)
                sb.check_cmds({cmd_out_bus.left_heat_cmd, cmd_out_bus.right_heat_cmd,
                               cmd_out_bus.left_vent_cmd, cmd_out_bus.right_vent_cmd,
                               cmd_out_bus.left_backrest_cmd, cmd_out_bus.right_backrest_cmd,
                               cmd_out_bus.key_sound});
            if ((key_in_bus.valid && key_in_bus.ready) ||
                (cmd_out_bus.valid && cmd_out_bus.ready) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // stall the result side in random bursts, with calm stretches between
    initial
    begin
        cmd_out_bus.ready <= 1'b0;
        out_calm = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (!quiet_run)
            begin
                if (out_calm > 0)
                    out_calm--;
                else
                begin
                    case ($urandom_range(0, 11))
                        0:
                        begin
                            cmd_out_bus.ready <= 1'b0;
                            repeat ($urandom_range(1, 13)) @(posedge clk);
                        end
                        1: out_calm = $urandom_range(20, 80);
                        default: ;
                    endcase
                end
            end
            cmd_out_bus.ready <= 1'b1;
        end
    end

    function automatic tksc_levels_t any_levels();
        return tksc_levels_t'(8'($urandom));
    endfunction

    // offer one scan tick request, hold it until taken, then maybe pause
    task automatic send_tick(logic [7:0] keys, tksc_levels_t lv);
        key_in_bus.valid            <= 1'b1;
        key_in_bus.touch_keys       <= keys;
        key_in_bus.left_vent_level  <= lv.left_vent_level;
        key_in_bus.right_vent_level <= lv.right_vent_level;
        key_in_bus.left_heat_level  <= lv.left_heat_level;
        key_in_bus.right_heat_level <= lv.right_heat_level;
        do
            @(posedge clk);
        while (!key_in_bus.ready);
        if (!quiet_run)
        begin
            if (in_calm > 0)
                in_calm--;
            else
            begin
                case ($urandom_range(0, 11))
                    0:
                    begin
                        key_in_bus.valid <= 1'b0;
                        repeat ($urandom_range(1, 13)) @(posedge clk);
                    end
                    1: in_calm = $urandom_range(20, 80);
                    default: ;
                endcase
            end
        end
    endtask

    task automatic hold_keys(logic [7:0] mask, int len, ref int sent);
        repeat (len)
        begin
            send_tick(mask, any_levels());
            sent++;
        end
    endtask

    // drain all outstanding requests, then write every register
    task automatic apply_settings(bit heat, bit vent, logic [7:0] deb, logic [7:0] lp,
                                  logic [1:0] rep);
        logic [CFG_IDX_W-1:0]  idx [6];
        logic [CFG_DATA_W-1:0] dat [6];
        logic [7:0]            junk;
        key_in_bus.valid <= 1'b0;
        // let the last accepted request reach the scoreboard before draining
        @(posedge clk);
        while (sb.expected_cmds.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        junk   = 8'($urandom);
        idx[0] = CFG_IDX_W'($urandom_range(CFG_REPEAT + 1, 7));
        dat[0] = CFG_DATA_W'($urandom);
        idx[1] = CFG_HEAT_EN;
        dat[1] = {junk[7:1], heat};
        idx[2] = CFG_VENT_EN;
        dat[2] = {junk[6:0], vent};
        idx[3] = CFG_DEBOUNCE;
        dat[3] = deb;
        idx[4] = CFG_LONG_PRESS;
        dat[4] = lp;
        idx[5] = CFG_REPEAT;
        dat[5] = {junk[5:0], rep};
        for (int i = 0; i < 6; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= dat[i];
            @(posedge clk);
            sb.write_reg(idx[i], dat[i]);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // mostly full presses with random content, some noise and cut-short presses
    task automatic run_presses(int n_items, int max_hold);
        int         sent;
        int         len;
        logic [7:0] mask;
        sent = 0;
        while (sent < n_items)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    repeat ($urandom_range(1, 4))
                    begin
                        send_tick(8'($urandom), any_levels());
                        sent++;
                    end
                end
                2:
                begin
                    mask = 8'($urandom_range(1, 255));
                    len  = $urandom_range(1, (sb.debounce > 0) ? sb.debounce : 1);
                    if (len > max_hold)
                        len = max_hold;
                    hold_keys(mask, len, sent);
                end
                default:
                begin
                    if ($urandom_range(0, 1) == 0)
                        mask = 8'h01 << $urandom_range(0, 7);
                    else
                        mask = 8'($urandom_range(1, 255));
                    if ($urandom_range(0, 3) == 0)
                        len = sb.long_press + 1 + $urandom_range(0, 4);
                    else
                        len = sb.debounce + 1 + $urandom_range(0, 3);
                    if (len > max_hold)
                        len = max_hold;
                    hold_keys(mask, len, sent);
                end
            endcase
            hold_keys(8'h00, $urandom_range(0, 2), sent);
        end
    endtask

    initial
    begin
        int n;
        sb          = new();
        quiet_run   = 1'b0;
        in_calm     = 0;
        idle_cycles = 0;
        n           = 0;
        rst_n                       <= 1'b0;
        cfg_we                      <= 1'b0;
        cfg_index                   <= '0;
        cfg_data                    <= '0;
        key_in_bus.valid            <= 1'b0;
        key_in_bus.touch_keys       <= '0;
        key_in_bus.left_vent_level  <= '0;
        key_in_bus.right_vent_level <= '0;
        key_in_bus.left_heat_level  <= '0;
        key_in_bus.right_heat_level <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all keys at reset settings: backward wins, heat and vent stay waiting
        hold_keys(8'hFF, 3, n);
        hold_keys(8'h00, 2, n);
        apply_settings(1'b1, 1'b1, 8'd1, 8'd20, 2'd3);
        // waiting heat and vent triggers act now on levels 0,1,2,3
        send_tick(8'h00, {2'd0, 2'd1, 2'd2, 2'd3});
        send_tick(8'h0F, {2'd3, 2'd2, 2'd1, 2'd0});
        send_tick(8'h0F, {2'd3, 2'd2, 2'd1, 2'd0});
        hold_keys(8'h00, 1, n);
        hold_keys(8'h50, 2, n);
        hold_keys(8'h00, 3, n);

        apply_settings(1'b1, 1'b1, 8'd1, 8'd4, 2'd1);
        run_presses(180, 30);
        // zero counts fire from the first touched tick
        apply_settings(1'b1, 1'b0, 8'd0, 8'd0, 2'd2);
        run_presses(200, 30);
        // top counts; one long hold runs the held count into saturation
        apply_settings(1'b0, 1'b1, 8'd255, 8'd255, 2'd3);
        hold_keys(8'($urandom_range(1, 255)), 300, n);
        hold_keys(8'h00, 2, n);
        run_presses(100, 40);
        // zero repeat hides every seat command
        apply_settings(1'b1, 1'b1, 8'd3, 8'd10, 2'd0);
        run_presses(150, 30);
        apply_settings(1'b0, 1'b0, 8'd2, 8'd20, 2'd3);
        run_presses(100, 30);
        apply_settings(1'b1, 1'b1, 8'd2, 8'd6, 2'd3);
        quiet_run = 1'b1;
        run_presses(150, 30);

        key_in_bus.valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_cmds.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_cmds.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ files.f @@
src/tksc_pkg.sv
src/tksc_if.sv
src/tksc_key_lane.sv
src/tksc_merge.sv
src/touch_key_seat_command_sequencer_top.sv
tb/sv/touch_key_seat_command_sequencer_top_tb.sv
